// ===== rtl/nlvp_pkg.sv =====
// ----------------------------------------------------------------------------
// nlvp_pkg: shared constants of the longest viable prefix matcher
// Action codes, token bytes, report status codes, edge labels and the
// default sizes of the node table, fragment stack and length counters.
// ----------------------------------------------------------------------------
package nlvp_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_STACK = 32;
    localparam int DEF_LEN_BITS  = 16;

    localparam logic [1:0] ACT_TOKEN  = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_SYMBOL = 2'd2;
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_EPS  = 8'h31;
    localparam logic [7:0] CH_ALT  = 8'h2B;
    localparam logic [7:0] CH_CAT  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OPERAND  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_LEFTOVER = 3'd3;
    localparam logic [2:0] ST_CAPACITY = 3'd4;
    localparam logic [2:0] ST_BAD_SYM  = 3'd5;

    localparam logic [1:0] LBL_EPS = 2'd3;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_WORD  = 1'b1;

endpackage

// ===== rtl/nfa_longest_viable_prefix.sv =====
// ----------------------------------------------------------------------------
// nfa_longest_viable_prefix: Thompson automaton builder and prefix matcher
// Builds an automaton from postfix regex tokens and reports, per word, the
// longest prefix after which the accept node is still reachable.
// ----------------------------------------------------------------------------
// Steps: a regex token holds the input off while its nodes and edges are written
// (not at all if it faults); finish goes straight to its report on a fault, else
// reads the remaining fragment and marks live nodes; a word symbol runs one move
// pass and its closure passes. Each pass walks the node table; passes repeat until nothing changes.
// Flow: one word at a time; a report waits in the output register while the
// next word is taken. Reset: synchronous, active low; memories are not cleared.
// ----------------------------------------------------------------------------
module nfa_longest_viable_prefix #(
    parameter int MAX_NODES = nlvp_pkg::DEF_MAX_NODES,
    parameter int MAX_STACK = nlvp_pkg::DEF_MAX_STACK,
    parameter int LEN_BITS  = nlvp_pkg::DEF_LEN_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_symbol,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_report_kind,
    output logic [2:0]  o_status,
    output logic [15:0] o_prefix_length
);
    import nlvp_pkg::*;

    // Widths follow from the sizes: node index, node count, stack index and level.
    localparam int NB  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int TW  = NB + 1;
    localparam int NSZ = 1 << NB;
    localparam int SB  = (MAX_STACK > 1) ? $clog2(MAX_STACK) : 1;
    localparam int LW  = SB + 1;

    // Sequencer states.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_POP1  = 5'd1;
    localparam logic [4:0] S_CAP1  = 5'd2;
    localparam logic [4:0] S_CAP2  = 5'd3;
    localparam logic [4:0] S_NEWS  = 5'd4;
    localparam logic [4:0] S_NEWT  = 5'd5;
    localparam logic [4:0] S_ERD   = 5'd6;
    localparam logic [4:0] S_EWR   = 5'd7;
    localparam logic [4:0] S_PUSH  = 5'd8;
    localparam logic [4:0] S_FRD   = 5'd9;
    localparam logic [4:0] S_FCAP  = 5'd10;
    localparam logic [4:0] S_FDONE = 5'd11;
    localparam logic [4:0] S_PASS  = 5'd12;
    localparam logic [4:0] S_PEND  = 5'd13;
    localparam logic [4:0] S_WEVAL = 5'd14;
    localparam logic [4:0] S_WPOST = 5'd15;
    localparam logic [4:0] S_WLAST = 5'd16;
    localparam logic [4:0] S_EMIT  = 5'd17;

    // Token operations.
    localparam logic [1:0] OP_SYM  = 2'd0;
    localparam logic [1:0] OP_CAT  = 2'd1;
    localparam logic [1:0] OP_ALT  = 2'd2;
    localparam logic [1:0] OP_STAR = 2'd3;

    // Modes of the shared pass engine over the node table.
    localparam logic [1:0] MD_LIVE = 2'd0;
    localparam logic [1:0] MD_CLOS = 2'd1;
    localparam logic [1:0] MD_MOVE = 2'd2;

    typedef struct packed {
        logic [1:0]    lbl;
        logic [NB-1:0] t1;
        logic [NB-1:0] t2;
        logic [1:0]    cnt;
    } t_node;

    typedef struct packed {
        logic [NB-1:0] s;
        logic [NB-1:0] a;
    } t_frag;

    // Node table and fragment stack memories.
    t_node node_mem [MAX_NODES];
    t_frag frag_mem [MAX_STACK];

    t_node r_nd_q;
    t_frag r_stk_q;

    logic          nd_we;
    logic [NB-1:0] nd_waddr, nd_raddr;
    t_node         nd_wdata;
    logic          stk_we;
    logic [SB-1:0] stk_waddr, stk_raddr;
    t_frag         stk_wdata;

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            node_mem[nd_waddr] <= nd_wdata;
        end
        r_nd_q <= node_mem[nd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            frag_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= frag_mem[stk_raddr];
    end

    // Control and datapath registers.
    logic [4:0]          r_state, n_state, r_ret, n_ret;
    logic [TW-1:0]       r_total, n_total;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [NB-1:0]       r_start, n_start, r_accept, n_accept;
    logic                r_fsa_ok, n_fsa_ok, r_building, n_building;
    logic [2:0]          r_fault, n_fault;
    logic [NSZ-1:0]      r_live, n_live, r_act, n_act, r_nxt, n_nxt;
    logic [LEN_BITS-1:0] r_pos, n_pos, r_best, n_best;
    logic                r_wact, n_wact, r_wdone, n_wdone, r_werr, n_werr;
    logic [1:0]          r_op, n_op, r_slbl, n_slbl, r_mode, n_mode;
    logic [7:0]          r_ch, n_ch;
    logic                r_last, n_last;
    logic [NB-1:0]       r_rs, n_rs, r_ra, n_ra, r_ls, n_ls, r_la, n_la;
    logic [NB-1:0]       r_s, n_s, r_t, n_t, r_u, n_u, r_pu, n_pu;
    logic                r_k, n_k, r_pv, n_pv, r_chg, n_chg;
    logic                r_rkind, n_rkind;
    logic [2:0]          r_rstat, n_rstat;
    logic [LEN_BITS-1:0] r_rlen, n_rlen;
    logic                r_ovalid, n_ovalid, r_okind, n_okind;
    logic [2:0]          r_ostat, n_ostat;
    logic [LEN_BITS-1:0] r_olen, n_olen;

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_report_kind   = r_okind;
    assign o_status        = r_ostat;
    assign o_prefix_length = 16'(r_olen);

    always_comb begin
        logic [TW-1:0] eff_total;
        logic [LW-1:0] eff_lvl;
        logic [2:0]    eff_fault;
        logic          room2, eval_chg, live_hit, two_ops;
        logic [NB-1:0] e_from, e_to;
        logic [LW-1:0] push_idx;
        logic          take;

        n_state = r_state;      n_ret = r_ret;
        n_total = r_total;      n_lvl = r_lvl;
        n_start = r_start;      n_accept = r_accept;
        n_fsa_ok = r_fsa_ok;    n_building = r_building;
        n_fault = r_fault;
        n_live = r_live;        n_act = r_act;      n_nxt = r_nxt;
        n_pos = r_pos;          n_best = r_best;
        n_wact = r_wact;        n_wdone = r_wdone;  n_werr = r_werr;
        n_op = r_op;            n_slbl = r_slbl;    n_mode = r_mode;
        n_ch = r_ch;            n_last = r_last;
        n_rs = r_rs;  n_ra = r_ra;  n_ls = r_ls;  n_la = r_la;
        n_s = r_s;    n_t = r_t;    n_u = r_u;    n_pu = r_pu;
        n_k = r_k;    n_pv = 1'b0;  n_chg = r_chg;
        n_rkind = r_rkind;  n_rstat = r_rstat;  n_rlen = r_rlen;
        n_ovalid = r_ovalid; n_okind = r_okind; n_ostat = r_ostat; n_olen = r_olen;

        nd_we = 1'b0;  nd_waddr = '0;  nd_raddr = '0;  nd_wdata = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_raddr = '0; stk_wdata = '0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        // A build that is not open starts over on any token or finish.
        eff_total = r_building ? r_total : '0;
        eff_lvl   = r_building ? r_lvl : '0;
        eff_fault = r_building ? r_fault : ST_OK;
        room2     = ((TW+1)'(eff_total) + (TW+1)'(2)) <= (TW+1)'(MAX_NODES);
        live_hit  = |(r_act & r_live);
        two_ops   = (r_op == OP_CAT) || (r_op == OP_ALT);
        take      = i_valid && (r_state == S_IDLE);

        // Edge insertion plan of the token being built.
        case (r_op)
            OP_CAT:  begin e_from = r_la; e_to = r_rs; end
            OP_ALT:  begin e_from = r_k ? r_ra : r_la; e_to = r_t; end
            default: begin e_from = r_ra; e_to = r_k ? r_t : r_rs; end
        endcase
        case (r_op)
            OP_SYM:  push_idx = r_lvl;
            OP_STAR: push_idx = r_lvl - LW'(1);
            default: push_idx = r_lvl - LW'(2);
        endcase

        // Shared pass engine: evaluates the node read in the previous cycle.
        eval_chg = 1'b0;
        if (r_pv) begin
            case (r_mode)
                MD_LIVE: begin
                    if (!r_live[r_pu] &&
                        ((r_nd_q.cnt != 2'd0 && r_live[r_nd_q.t1]) ||
                         (r_nd_q.cnt == 2'd2 && r_live[r_nd_q.t2]))) begin
                        n_live[r_pu] = 1'b1;
                        eval_chg = 1'b1;
                    end
                end
                MD_CLOS: begin
                    if (r_act[r_pu] && r_nd_q.lbl == LBL_EPS) begin
                        if (r_nd_q.cnt != 2'd0 && TW'(r_nd_q.t1) < r_total &&
                            !n_act[r_nd_q.t1]) begin
                            n_act[r_nd_q.t1] = 1'b1;
                            eval_chg = 1'b1;
                        end
                        if (r_nd_q.cnt == 2'd2 && TW'(r_nd_q.t2) < r_total &&
                            !n_act[r_nd_q.t2]) begin
                            n_act[r_nd_q.t2] = 1'b1;
                            eval_chg = 1'b1;
                        end
                    end
                end
                default: begin
                    if (r_act[r_pu] && r_nd_q.lbl == r_slbl) begin
                        if (r_nd_q.cnt != 2'd0 && TW'(r_nd_q.t1) < r_total) begin
                            n_nxt[r_nd_q.t1] = 1'b1;
                        end
                        if (r_nd_q.cnt == 2'd2 && TW'(r_nd_q.t2) < r_total) begin
                            n_nxt[r_nd_q.t2] = 1'b1;
                        end
                    end
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_ch   = i_char_code;
                    n_last = i_last_symbol;
                    if (i_action == ACT_TOKEN || i_action == ACT_FINISH) begin
                        if (!r_building) begin
                            n_total  = '0;
                            n_lvl    = '0;
                            n_fsa_ok = 1'b0;
                            n_fault  = ST_OK;
                            n_live   = '0;
                            n_act    = '0;
                        end
                        n_wact = 1'b0; n_wdone = 1'b0; n_werr = 1'b0;
                    end
                    case (i_action)
                        ACT_TOKEN: begin
                            n_building = 1'b1;
                            if (eff_fault == ST_OK) begin
                                case (i_char_code) inside
                                    CH_A, CH_B, CH_C, CH_EPS: begin
                                        if (!room2 || eff_lvl >= LW'(MAX_STACK)) begin
                                            n_fault = ST_CAPACITY;
                                        end else begin
                                            n_op    = OP_SYM;
                                            n_slbl  = (i_char_code == CH_EPS) ? LBL_EPS
                                                    : 2'(i_char_code - CH_A);
                                            n_state = S_NEWS;
                                        end
                                    end
                                    CH_ALT, CH_CAT: begin
                                        if (eff_lvl < LW'(2)) begin
                                            n_fault = ST_OPERAND;
                                        end else if (i_char_code == CH_ALT && !room2) begin
                                            n_fault = ST_CAPACITY;
                                        end else begin
                                            n_op    = (i_char_code == CH_ALT) ? OP_ALT : OP_CAT;
                                            n_state = S_POP1;
                                        end
                                    end
                                    CH_STAR: begin
                                        if (eff_lvl == '0) begin
                                            n_fault = ST_OPERAND;
                                        end else if (!room2) begin
                                            n_fault = ST_CAPACITY;
                                        end else begin
                                            n_op    = OP_STAR;
                                            n_state = S_POP1;
                                        end
                                    end
                                    default: n_fault = ST_UNKNOWN;
                                endcase
                            end
                        end
                        ACT_FINISH: begin
                            n_building = 1'b0;
                            if (eff_fault == ST_OK && eff_lvl != LW'(1)) begin
                                n_fault = ST_LEFTOVER;
                                n_rkind = KIND_BUILD;
                                n_rstat = ST_LEFTOVER;
                                n_rlen  = '0;
                                n_state = S_EMIT;
                            end else if (eff_fault != ST_OK) begin
                                n_rkind = KIND_BUILD;
                                n_rstat = eff_fault;
                                n_rlen  = '0;
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_FRD;
                            end
                        end
                        ACT_SYMBOL: begin
                            n_state = S_WEVAL;
                            if (!r_wact) begin
                                n_act   = '0;
                                n_pos   = '0;
                                n_best  = '0;
                                n_wact  = 1'b1;
                                n_wdone = 1'b0;
                                n_werr  = 1'b0;
                                if (r_fsa_ok) begin
                                    n_act[r_start] = 1'b1;
                                    n_mode  = MD_CLOS;
                                    n_u     = '0;
                                    n_chg   = 1'b0;
                                    n_ret   = S_WEVAL;
                                    n_state = S_PASS;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP1: begin
                stk_raddr = SB'(r_lvl - LW'(1));
                n_state   = S_CAP1;
            end
            S_CAP1: begin
                n_rs = r_stk_q.s;
                n_ra = r_stk_q.a;
                if (two_ops) begin
                    stk_raddr = SB'(r_lvl - LW'(2));
                    n_state   = S_CAP2;
                end else begin
                    n_state = S_NEWS;
                end
            end
            S_CAP2: begin
                n_ls = r_stk_q.s;
                n_la = r_stk_q.a;
                n_k  = 1'b0;
                n_state = (r_op == OP_CAT) ? S_ERD : S_NEWS;
            end
            S_NEWS: begin
                nd_we    = 1'b1;
                nd_waddr = NB'(r_total);
                case (r_op)
                    OP_SYM:  nd_wdata = '{lbl: r_slbl, t1: NB'(r_total + TW'(1)),
                                          t2: '0, cnt: 2'd1};
                    OP_ALT:  nd_wdata = '{lbl: LBL_EPS, t1: r_ls, t2: r_rs, cnt: 2'd2};
                    default: nd_wdata = '{lbl: LBL_EPS, t1: r_rs,
                                          t2: NB'(r_total + TW'(1)), cnt: 2'd2};
                endcase
                n_s     = NB'(r_total);
                n_total = r_total + TW'(1);
                n_state = S_NEWT;
            end
            S_NEWT: begin
                nd_we    = 1'b1;
                nd_waddr = NB'(r_total);
                nd_wdata = '{lbl: LBL_EPS, t1: '0, t2: '0, cnt: 2'd0};
                n_t      = NB'(r_total);
                n_total  = r_total + TW'(1);
                n_k      = 1'b0;
                n_state  = (r_op == OP_SYM) ? S_PUSH : S_ERD;
            end
            S_ERD: begin
                nd_raddr = e_from;
                n_state  = S_EWR;
            end
            S_EWR: begin
                nd_we    = 1'b1;
                nd_waddr = e_from;
                nd_wdata = r_nd_q;
                if (r_nd_q.cnt == 2'd0) begin
                    nd_wdata.lbl = LBL_EPS;
                    nd_wdata.t1  = e_to;
                    nd_wdata.cnt = 2'd1;
                end else if (r_nd_q.cnt == 2'd1) begin
                    nd_wdata.t2  = e_to;
                    nd_wdata.cnt = 2'd2;
                end
                if (r_op != OP_CAT && !r_k) begin
                    n_k     = 1'b1;
                    n_state = S_ERD;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = SB'(push_idx);
                stk_wdata = (r_op == OP_CAT) ? '{s: r_ls, a: r_ra} : '{s: r_s, a: r_t};
                n_lvl     = push_idx + LW'(1);
                n_state   = S_IDLE;
            end
            S_FRD: begin
                stk_raddr = '0;
                n_state   = S_FCAP;
            end
            S_FCAP: begin
                n_start  = r_stk_q.s;
                n_accept = r_stk_q.a;
                n_live   = '0;
                n_live[r_stk_q.a] = 1'b1;
                n_mode   = MD_LIVE;
                n_u      = '0;
                n_chg    = 1'b0;
                n_ret    = S_FDONE;
                n_state  = S_PASS;
            end
            S_FDONE: begin
                n_fsa_ok = 1'b1;
                n_rkind  = KIND_BUILD;
                n_rstat  = ST_OK;
                n_rlen   = '0;
                n_state  = S_EMIT;
            end
            S_PASS: begin
                nd_raddr = r_u;
                n_pv     = 1'b1;
                n_pu     = r_u;
                n_chg    = r_chg | eval_chg;
                if (TW'(r_u) == r_total - TW'(1)) begin
                    n_state = S_PEND;
                end else begin
                    n_u = r_u + NB'(1);
                end
            end
            S_PEND: begin
                n_u   = '0;
                n_chg = 1'b0;
                if (r_mode == MD_MOVE) begin
                    // The stepped set is complete; close it over epsilon edges.
                    n_act   = n_nxt;
                    n_mode  = MD_CLOS;
                    n_state = S_PASS;
                end else if (r_chg || eval_chg) begin
                    n_state = S_PASS;
                end else begin
                    n_state = r_ret;
                end
            end
            S_WEVAL: begin
                n_state = S_WLAST;
                if (r_fsa_ok && !r_wdone && !r_werr) begin
                    if (live_hit) begin
                        n_best = r_pos;
                    end
                    if (r_ch inside {CH_A, CH_B, CH_C}) begin
                        n_slbl  = 2'(r_ch - CH_A);
                        n_nxt   = '0;
                        n_mode  = MD_MOVE;
                        n_u     = '0;
                        n_chg   = 1'b0;
                        n_ret   = S_WPOST;
                        n_state = S_PASS;
                    end else begin
                        n_werr = 1'b1;
                    end
                end
            end
            S_WPOST: begin
                if (r_pos != '1) begin
                    n_pos = r_pos + LEN_BITS'(1);
                end
                if (r_act == '0) begin
                    n_wdone = 1'b1;
                end
                n_state = S_WLAST;
            end
            S_WLAST: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_rkind = KIND_WORD;
                    n_rstat = ST_OK;
                    n_rlen  = r_best;
                    if (r_fsa_ok && !r_wdone && !r_werr && live_hit) begin
                        n_rlen = r_pos;
                    end
                    if (!r_fsa_ok) begin
                        n_rlen = '0;
                    end
                    if (r_werr) begin
                        n_rstat = ST_BAD_SYM;
                        n_rlen  = '0;
                    end
                    n_best  = n_rlen;
                    n_wact  = 1'b0;
                    n_wdone = 1'b0;
                    n_werr  = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_rkind;
                    n_ostat  = r_rstat;
                    n_olen   = r_rlen;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_total    <= '0;
            r_lvl      <= '0;
            r_start    <= '0;
            r_accept   <= '0;
            r_fsa_ok   <= 1'b0;
            r_building <= 1'b0;
            r_fault    <= ST_OK;
            r_live     <= '0;
            r_act      <= '0;
            r_nxt      <= '0;
            r_pos      <= '0;
            r_best     <= '0;
            r_wact     <= 1'b0;
            r_wdone    <= 1'b0;
            r_werr     <= 1'b0;
            r_mode     <= MD_LIVE;
            r_pv       <= 1'b0;
            r_chg      <= 1'b0;
            r_u        <= '0;
            r_k        <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_total    <= n_total;
            r_lvl      <= n_lvl;
            r_start    <= n_start;
            r_accept   <= n_accept;
            r_fsa_ok   <= n_fsa_ok;
            r_building <= n_building;
            r_fault    <= n_fault;
            r_live     <= n_live;
            r_act      <= n_act;
            r_nxt      <= n_nxt;
            r_pos      <= n_pos;
            r_best     <= n_best;
            r_wact     <= n_wact;
            r_wdone    <= n_wdone;
            r_werr     <= n_werr;
            r_mode     <= n_mode;
            r_pv       <= n_pv;
            r_chg      <= n_chg;
            r_u        <= n_u;
            r_k        <= n_k;
            r_ovalid   <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_slbl  <= n_slbl;
        r_ch    <= n_ch;
        r_last  <= n_last;
        r_rs    <= n_rs;
        r_ra    <= n_ra;
        r_ls    <= n_ls;
        r_la    <= n_la;
        r_s     <= n_s;
        r_t     <= n_t;
        r_pu    <= n_pu;
        r_rkind <= n_rkind;
        r_rstat <= n_rstat;
        r_rlen  <= n_rlen;
        r_okind <= n_okind;
        r_ostat <= n_ostat;
        r_olen  <= n_olen;
    end

endmodule

// ===== sim/nlvp_report_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nlvp_report_checker: prediction and comparison of matcher reports
// Watches both channels of the matcher, runs its own model of the automaton
// on every accepted input word and compares each accepted report with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module nlvp_report_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_symbol,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_report_kind,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_prefix_length,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_reports
);
    import nlvp_pkg::*;

    localparam int NN = DEF_MAX_NODES;
    localparam int NS = DEF_MAX_STACK;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [15:0] length;
    } t_report;

    t_report      pending_reports[$];

    logic [1:0]   lbl[NN];
    int           tgt0[NN], tgt1[NN], ecnt[NN];
    bit           live[NN];
    int           ntot, sp, snode, anode;
    int           fstart[NS], faccept[NS];
    bit           have_nfa, bld;
    logic [2:0]   fault;
    bit [NN-1:0]  act;
    int           pos, best;
    bit           w_act, w_done, w_err;

    function automatic int new_node();
        int id;
        id = ntot;
        ntot++;
        lbl[id] = LBL_EPS;
        ecnt[id] = 0;
        tgt0[id] = 0;
        tgt1[id] = 0;
        live[id] = 0;
        return id;
    endfunction

    function automatic void link(int from, int to, logic [1:0] l);
        if (ecnt[from] == 0) begin
            lbl[from] = l;
            tgt0[from] = to;
            ecnt[from] = 1;
        end else if (ecnt[from] == 1) begin
            tgt1[from] = to;
            ecnt[from] = 2;
        end
    endfunction

    function automatic int edge_to(int u, int k);
        return (k == 0) ? tgt0[u] : tgt1[u];
    endfunction

    function automatic void eps_close();
        bit changed;
        int v;
        changed = 1;
        while (changed) begin
            changed = 0;
            for (int u = 0; u < ntot; u++) begin
                if (act[u] && lbl[u] == LBL_EPS) begin
                    for (int k = 0; k < ecnt[u]; k++) begin
                        v = edge_to(u, k);
                        if (v < ntot && !act[v]) begin
                            act[v] = 1;
                            changed = 1;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void step_on(logic [1:0] sym);
        bit [NN-1:0] nxt;
        nxt = '0;
        for (int u = 0; u < ntot; u++)
            if (act[u] && lbl[u] == sym)
                for (int k = 0; k < ecnt[u]; k++)
                    if (edge_to(u, k) < ntot) nxt[edge_to(u, k)] = 1;
        act = nxt;
        eps_close();
    endfunction

    function automatic bit any_live();
        for (int u = 0; u < ntot; u++)
            if (act[u] && live[u]) return 1;
        return 0;
    endfunction

    function automatic void mark_live();
        bit changed;
        for (int u = 0; u < NN; u++) live[u] = 0;
        live[anode] = 1;
        changed = 1;
        while (changed) begin
            changed = 0;
            for (int u = 0; u < ntot; u++) begin
                if (!live[u]) begin
                    for (int k = 0; k < ecnt[u]; k++) begin
                        if (!live[u] && live[edge_to(u, k)]) begin
                            live[u] = 1;
                            changed = 1;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void open_build();
        ntot = 0;
        sp = 0;
        have_nfa = 0;
        fault = ST_OK;
        bld = 1;
        for (int u = 0; u < NN; u++) live[u] = 0;
        act = '0;
    endfunction

    function automatic void clear_word();
        w_act = 0;
        w_done = 0;
        w_err = 0;
    endfunction

    function automatic void apply_token(logic [7:0] ch);
        int s, t, ls, la, rs, ra;
        if (!bld) open_build();
        clear_word();
        if (fault != ST_OK) return;
        if (ch == CH_A || ch == CH_B || ch == CH_C || ch == CH_EPS) begin
            if (ntot + 2 > NN || sp >= NS) begin
                fault = ST_CAPACITY;
                return;
            end
            s = new_node();
            t = new_node();
            link(s, t, (ch == CH_EPS) ? LBL_EPS : 2'(ch - CH_A));
            fstart[sp] = s;
            faccept[sp] = t;
            sp++;
        end else if (ch == CH_ALT || ch == CH_CAT) begin
            if (sp < 2) begin
                fault = ST_OPERAND;
                return;
            end
            if (ch == CH_ALT && ntot + 2 > NN) begin
                fault = ST_CAPACITY;
                return;
            end
            rs = fstart[sp-1];
            ra = faccept[sp-1];
            ls = fstart[sp-2];
            la = faccept[sp-2];
            sp -= 2;
            if (ch == CH_CAT) begin
                link(la, rs, LBL_EPS);
                s = ls;
                t = ra;
            end else begin
                s = new_node();
                t = new_node();
                link(s, ls, LBL_EPS);
                link(s, rs, LBL_EPS);
                link(la, t, LBL_EPS);
                link(ra, t, LBL_EPS);
            end
            fstart[sp] = s;
            faccept[sp] = t;
            sp++;
        end else if (ch == CH_STAR) begin
            if (sp < 1) begin
                fault = ST_OPERAND;
                return;
            end
            if (ntot + 2 > NN) begin
                fault = ST_CAPACITY;
                return;
            end
            ls = fstart[sp-1];
            la = faccept[sp-1];
            sp -= 1;
            s = new_node();
            t = new_node();
            link(s, ls, LBL_EPS);
            link(s, t, LBL_EPS);
            link(la, ls, LBL_EPS);
            link(la, t, LBL_EPS);
            fstart[sp] = s;
            faccept[sp] = t;
            sp++;
        end else begin
            fault = ST_UNKNOWN;
        end
    endfunction

    function automatic void predict_word(logic [1:0] a, logic [7:0] ch, logic last);
        t_report r;
        bit sym_ok;
        sym_ok = (ch == CH_A || ch == CH_B || ch == CH_C);
        if (a == ACT_TOKEN) begin
            apply_token(ch);
        end else if (a == ACT_FINISH) begin
            if (!bld) open_build();
            clear_word();
            if (fault == ST_OK && sp != 1) fault = ST_LEFTOVER;
            if (fault == ST_OK) begin
                snode = fstart[0];
                anode = faccept[0];
                mark_live();
                have_nfa = 1;
            end
            bld = 0;
            r = '{KIND_BUILD, fault, 16'd0};
            pending_reports = {pending_reports, r};
        end else if (a == ACT_SYMBOL) begin
            if (!w_act) begin
                act = '0;
                if (have_nfa) begin
                    act[snode] = 1;
                    eps_close();
                end
                pos = 0;
                best = 0;
                w_act = 1;
                w_done = 0;
                w_err = 0;
            end
            if (have_nfa && !w_done && !w_err) begin
                if (any_live()) best = pos;
                if (!sym_ok) begin
                    w_err = 1;
                end else begin
                    step_on(2'(ch - CH_A));
                    if (pos < 65535) pos++;
                    if (act == '0) w_done = 1;
                end
            end
            if (last) begin
                if (have_nfa && !w_done && !w_err && any_live()) best = pos;
                if (!have_nfa) best = 0;
                r = '{KIND_WORD, ST_OK, 16'(best)};
                if (w_err) r = '{KIND_WORD, ST_BAD_SYM, 16'd0};
                pending_reports = {pending_reports, r};
                clear_word();
            end
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_reports = 0;
        o_pending = 0;
        ntot = 0;
        sp = 0;
        snode = 0;
        anode = 0;
        have_nfa = 0;
        bld = 0;
        fault = ST_OK;
        act = '0;
        pos = 0;
        best = 0;
        clear_word();
        for (int u = 0; u < NN; u++) live[u] = 0;
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                o_reports <= o_reports + 1;
                if (pending_reports.size() == 0) begin
                    $error("report with none predicted: kind %0d status %0d length %0d",
                           i_report_kind, i_status, i_prefix_length);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_reports.pop_front();
                    if (i_report_kind !== want.kind || i_status !== want.status ||
                        i_prefix_length !== want.length) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_report_kind !== want.kind)
                            $error("report_kind: expected %0d, got %0d",
                                   want.kind, i_report_kind);
                        if (i_status !== want.status)
                            $error("status: expected %0d, got %0d", want.status, i_status);
                        if (i_prefix_length !== want.length)
                            $error("prefix_length: expected %0d, got %0d",
                                   want.length, i_prefix_length);
                    end
                end
            end
            if (i_valid && i_ready_in)
                predict_word(i_action, i_char_code, i_last_symbol);
        end
        o_pending <= pending_reports.size();
    end

endmodule

// ===== sim/nfa_longest_viable_prefix_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfa_longest_viable_prefix_test: top level of the matcher testbench
// Drives regex tokens, finish commands and word symbols into the matcher,
// stalls both sides at random and lets the report checker judge the results.
// ----------------------------------------------------------------------------
module nfa_longest_viable_prefix_test;
    import nlvp_pkg::*;

    // The slowest words walk a full node table many times over, so the
    // limit is taken far above what a correct run needs.
    localparam int CYCLE_LIMIT = 25000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [7:0]  i_char_code;
    logic        i_last_symbol;
    logic        o_valid;
    logic        i_ready;
    logic        o_report_kind;
    logic [2:0]  o_status;
    logic [15:0] o_prefix_length;

    int          fail_count;
    int          pending;
    int          reports;
    int          words_sent;
    int          builds_sent;
    int          cycles;
    bit          calm;
    bit          stall_ask;
    logic [7:0]  regex_tokens[$];

    nfa_longest_viable_prefix u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_last_symbol   (i_last_symbol),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_report_kind   (o_report_kind),
        .o_status        (o_status),
        .o_prefix_length (o_prefix_length)
    );

    nlvp_report_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_ready_in      (o_ready),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_last_symbol   (i_last_symbol),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_report_kind   (o_report_kind),
        .i_status        (o_status),
        .i_prefix_length (o_prefix_length),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_reports       (reports)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // The cycle counter guards against a block that hangs.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("nfa_longest_viable_prefix_test: errors");
            $finish;
        end
    end

    // The receiver drops ready about 16 times in a hundred, except in calm
    // stretches. On request it holds off for a long stretch so that the
    // output register and the sequencer fill and the input side stalls.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_ask) begin
                i_ready <= 1'b0;
                repeat (4000) @(posedge i_clk);
                stall_ask = 0;
            end
            i_ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // Offers one word and returns at the edge where it was accepted. Valid
    // stays high between back-to-back words unless a random gap falls.
    task automatic send_word(logic [1:0] act, logic [7:0] ch, logic last);
        if (!calm && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_char_code   <= ch;
        i_last_symbol <= last;
        words_sent++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_regex(string rx);
        for (int i = 0; i < rx.len(); i++) send_word(ACT_TOKEN, rx[i], 1'b0);
        send_word(ACT_FINISH, 8'($urandom), 1'($urandom));
        builds_sent++;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_word(ACT_SYMBOL, txt[i], i == txt.len() - 1);
    endtask

    // Builds a random well-formed postfix expression into regex_tokens.
    task automatic grow_regex(int depth);
        int pick;
        pick = $urandom_range(9);
        if (depth == 0 || pick < 4) begin
            case ($urandom_range(6))
                0, 1:    regex_tokens = {regex_tokens, CH_A};
                2, 3:    regex_tokens = {regex_tokens, CH_B};
                4:       regex_tokens = {regex_tokens, CH_C};
                default: regex_tokens = {regex_tokens, CH_EPS};
            endcase
        end else if (pick < 6) begin
            grow_regex(depth - 1);
            regex_tokens = {regex_tokens, CH_STAR};
        end else begin
            grow_regex(depth - 1);
            grow_regex(depth - 1);
            regex_tokens = {regex_tokens, (pick < 8) ? CH_CAT : CH_ALT};
        end
    endtask

    function automatic logic [7:0] word_symbol();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return CH_A;
        if (pick < 75) return CH_B;
        if (pick < 95) return CH_C;
        return 8'($urandom);
    endfunction

    initial begin
        int len;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ACT_TOKEN;
        i_char_code   = 8'd0;
        i_last_symbol = 1'b0;
        calm          = 0;
        stall_ask     = 0;
        words_sent    = 0;
        builds_sent   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a word before any automaton exists, the empty
        // expression, every token, the error cases and interrupted words.
        send_text("ab");
        send_word(ACT_FINISH, 8'h00, 1'b0);
        send_regex("ab.c+*1.");
        send_text("abcab");
        send_word(ACT_SYMBOL, 8'hFF, 1'b0);
        send_word(ACT_SYMBOL, CH_A, 1'b1);
        send_word(ACT_SYMBOL, 8'h00, 1'b1);
        send_word(ACT_SPARE, 8'hA5, 1'b1);
        send_word(ACT_SYMBOL, CH_C, 1'b0);
        send_regex("+");
        send_regex("ax");
        send_regex("ab");
        send_text("c");

        // Capacity: more leaf fragments than the stack holds.
        for (int i = 0; i < DEF_MAX_STACK + 1; i++) send_word(ACT_TOKEN, CH_A, 1'b0);
        send_word(ACT_FINISH, 8'h00, 1'b0);

        // Random part: mostly good expressions with a few words each; the
        // rest is noise, broken expressions and interrupted words.
        while (words_sent < 1100) begin
            if (words_sent > 300 && words_sent < 340) calm = 1;
            else calm = 0;
            if (words_sent > 600 && words_sent < 604) stall_ask = 1;
            case ($urandom_range(9))
                0: begin
                    send_word(ACT_TOKEN, 8'($urandom), 1'b0);
                    send_word(2'($urandom), 8'($urandom), 1'($urandom));
                end
                1: begin
                    regex_tokens.delete();
                    grow_regex(2);
                    regex_tokens.delete($urandom_range(regex_tokens.size() - 1));
                    foreach (regex_tokens[i]) send_word(ACT_TOKEN, regex_tokens[i], 1'b0);
                    send_word(ACT_FINISH, 8'($urandom), 1'($urandom));
                end
                default: begin
                    regex_tokens.delete();
                    grow_regex($urandom_range(99) < 5 ? 4 : 3);
                    foreach (regex_tokens[i])
                        send_word(ACT_TOKEN, regex_tokens[i], 1'($urandom));
                    send_word(ACT_FINISH, 8'($urandom), 1'($urandom));
                    builds_sent++;
                    repeat ($urandom_range(1, 4)) begin
                        len = $urandom_range(1, 8);
                        for (int i = 0; i < len; i++)
                            send_word(ACT_SYMBOL, word_symbol(), i == len - 1);
                    end
                    if ($urandom_range(3) == 0) send_word(ACT_SYMBOL, word_symbol(), 1'b0);
                end
            endcase
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);

        $display("Sent %0d input words and finished %0d regex builds; %0d reports checked.",
                 words_sent, builds_sent, reports);
        if (fail_count == 0 && pending == 0) begin
            $display("nfa_longest_viable_prefix_test: clean");
        end else begin
            $display("nfa_longest_viable_prefix_test: errors");
        end
        $finish;
    end

endmodule
